@@ design/e2r_pkg.sv @@
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types, CORDIC constants and fixed-point helpers for the Euler-angle
// to rotation-matrix core.
// ----------------------------------------------------------------------------
package e2r_pkg;

	localparam int FIELD_W     = 16;
	localparam int OUT_W       = 16;
	localparam int INT_FRAC    = 30;
	localparam int CORDIC_ITER = 30;
	localparam int TRIG_W      = 32;   // Q2.30 sine/cosine, |v| < 2^31
	localparam int PROD_W      = 33;   // rounded Q2.30 product
	localparam int SUM_W       = 35;   // sum of two products, with headroom
	localparam int CDC_W       = 34;   // CORDIC x/y/z working width

	localparam logic signed [CDC_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;

	typedef logic signed [FIELD_W-1:0] angle_t;
	typedef logic signed [OUT_W-1:0]   coef_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [CDC_W-1:0]   cdc_t;

	typedef struct packed {
		coef_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
	} mat_t;

	// atan(2^-i), 2^32 units per turn
	function automatic cdc_t atan_lut(input int i);
		cdc_t r;
		unique case (i)
			0: r = 34'sd536870912;
			1: r = 34'sd316933406;
			2: r = 34'sd167458907;
			3: r = 34'sd85004756;
			4: r = 34'sd42667331;
			5: r = 34'sd21354465;
			6: r = 34'sd10679838;
			7: r = 34'sd5340245;
			8: r = 34'sd2670163;
			9: r = 34'sd1335087;
			10: r = 34'sd667544;
			11: r = 34'sd333772;
			12: r = 34'sd166886;
			13: r = 34'sd83443;
			14: r = 34'sd41721;
			15: r = 34'sd20860;
			16: r = 34'sd10430;
			17: r = 34'sd5215;
			18: r = 34'sd2607;
			19: r = 34'sd1303;
			20: r = 34'sd651;
			21: r = 34'sd325;
			22: r = 34'sd162;
			23: r = 34'sd81;
			24: r = 34'sd40;
			25: r = 34'sd20;
			26: r = 34'sd10;
			27: r = 34'sd5;
			28: r = 34'sd2;
			29: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q2.30 x Q2.30, rounded half up, floor shift
	function automatic prod_t mulq(input trig_t u, input trig_t v);
		logic signed [2*TRIG_W-1:0] p;
		p = (2*TRIG_W)'(u) * (2*TRIG_W)'(v);
		p = p + (64'sd1 <<< (INT_FRAC - 1));
		p = p >>> INT_FRAC;
		return p[PROD_W-1:0];
	endfunction

endpackage

@@ design/e2r_angle_if.sv @@
// ----------------------------------------------------------------------------
// e2r_angle_if
// Valid/ready channel carrying roll, pitch and yaw binary angles.
// ----------------------------------------------------------------------------
interface e2r_angle_if;
	logic                   valid;
	logic                   ready;
	e2r_pkg::angle_t        roll_angle;
	e2r_pkg::angle_t        pitch_angle;
	e2r_pkg::angle_t        yaw_angle;

	modport source(output valid, output roll_angle, output pitch_angle,
		output yaw_angle, input ready);
	modport sink(input valid, input roll_angle, input pitch_angle,
		input yaw_angle, output ready);
endinterface

@@ design/e2r_mat_if.sv @@
// ----------------------------------------------------------------------------
// e2r_mat_if
// Valid/ready channel carrying the nine Q2.14 rotation matrix entries.
// ----------------------------------------------------------------------------
interface e2r_mat_if;
	logic            valid;
	logic            ready;
	e2r_pkg::coef_t  r00, r01, r02, r10, r11, r12, r20, r21, r22;

	modport source(output valid, output r00, output r01, output r02,
		output r10, output r11, output r12, output r20, output r21,
		output r22, input ready);
	modport sink(input valid, input r00, input r01, input r02,
		input r10, input r11, input r12, input r20, input r21,
		input r22, output ready);
endinterface

@@ design/e2r_cordic.sv @@
// ----------------------------------------------------------------------------
// e2r_cordic
// Fully pipelined rotation-mode CORDIC: one register stage per iteration,
// quadrant fold on entry and exit.
// ----------------------------------------------------------------------------
module e2r_cordic #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic             clk,
	input  logic             en,
	input  e2r_pkg::angle_t  angle,
	output e2r_pkg::trig_t   sin_o,
	output e2r_pkg::trig_t   cos_o
);
	import e2r_pkg::*;

	localparam int N = CORDIC_ITER;

	logic [63:0] phase64;
	logic [31:0] phase;
	logic [31:0] pu;

	cdc_t       x_s [0:N];
	cdc_t       y_s [0:N];
	cdc_t       z_s [0:N];
	logic [1:0] q_s [0:N];

	always_comb begin
		phase64 = (64'({16'b0, angle}) & ((64'd1 << ANGLE_WIDTH) - 64'd1))
			<< (32 - ANGLE_WIDTH);
		phase   = phase64[31:0];
		pu      = phase + 32'h2000_0000;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s[0] <= pu[31:30];
			z_s[0] <= cdc_t'($signed({4'b0, pu[29:0]})) - cdc_t'(34'sh2000_0000);
			x_s[0] <= CORDIC_INV_GAIN;
			y_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		cdc_t dx, dy;
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= q_s[i];
				if (!z_s[i][CDC_W-1]) begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - atan_lut(i);
				end else begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + atan_lut(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case (q_s[N])
				2'd0: begin cos_o <= trig_t'(x_s[N]);  sin_o <= trig_t'(y_s[N]);  end
				2'd1: begin cos_o <= trig_t'(-y_s[N]); sin_o <= trig_t'(x_s[N]);  end
				2'd2: begin cos_o <= trig_t'(-x_s[N]); sin_o <= trig_t'(-y_s[N]); end
				default: begin cos_o <= trig_t'(y_s[N]); sin_o <= trig_t'(-x_s[N]); end
			endcase
		end
	end

endmodule

@@ design/e2r_matrix.sv @@
// ----------------------------------------------------------------------------
// e2r_matrix
// Three-stage product/sum pipeline: pair products, triple products, then
// rounding to the output format with saturation.
// ----------------------------------------------------------------------------
module e2r_matrix #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            en,
	input  e2r_pkg::trig_t  sa, ca, sb, cb, sc, cc,
	output e2r_pkg::mat_t   mat
);
	import e2r_pkg::*;

	localparam int SH = INT_FRAC - COEF_FRAC_BITS;
	localparam logic signed [SUM_W-1:0] RND =
		(SH > 0) ? (SUM_W'(1) <<< ((SH > 0) ? SH - 1 : 0)) : '0;

	function automatic coef_t to_out(input sum_t v);
		sum_t r;
		r = (v + RND) >>> SH;
		if (r > sum_t'(32767))       return coef_t'(16'sd32767);
		else if (r < sum_t'(-32768)) return coef_t'(-16'sd32768);
		else                         return r[OUT_W-1:0];
	endfunction

	// stage 1
	prod_t t1_s1, t2_s1, ccca_s1, cbsa_s1, scca_s1, ccsa_s1, cbca_s1, scsa_s1,
		sccb_s1, cccb_s1;
	trig_t sa_s1, ca_s1, sb_s1;
	// stage 2
	prod_t t1sa_s2, t2sa_s2, t1ca_s2, t2ca_s2, ccca_s2, cbsa_s2, scca_s2,
		ccsa_s2, cbca_s2, scsa_s2, sccb_s2, cccb_s2;
	trig_t sb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			t1_s1   <= mulq(sc, sb);
			t2_s1   <= mulq(cc, sb);
			ccca_s1 <= mulq(cc, ca);
			cbsa_s1 <= mulq(cb, sa);
			scca_s1 <= mulq(sc, ca);
			ccsa_s1 <= mulq(cc, sa);
			cbca_s1 <= mulq(cb, ca);
			scsa_s1 <= mulq(sc, sa);
			sccb_s1 <= mulq(sc, cb);
			cccb_s1 <= mulq(cc, cb);
			sa_s1   <= sa;
			ca_s1   <= ca;
			sb_s1   <= sb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t1sa_s2 <= mulq(trig_t'(t1_s1), sa_s1);
			t2sa_s2 <= mulq(trig_t'(t2_s1), sa_s1);
			t1ca_s2 <= mulq(trig_t'(t1_s1), ca_s1);
			t2ca_s2 <= mulq(trig_t'(t2_s1), ca_s1);
			ccca_s2 <= ccca_s1;
			cbsa_s2 <= cbsa_s1;
			scca_s2 <= scca_s1;
			ccsa_s2 <= ccsa_s1;
			cbca_s2 <= cbca_s1;
			scsa_s2 <= scsa_s1;
			sccb_s2 <= sccb_s1;
			cccb_s2 <= cccb_s1;
			sb_s2   <= sb_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat.r00 <= to_out(sum_t'(t1sa_s2) + sum_t'(ccca_s2));
			mat.r01 <= to_out(sum_t'(cbsa_s2));
			mat.r02 <= to_out(sum_t'(scca_s2) - sum_t'(t2sa_s2));
			mat.r10 <= to_out(sum_t'(t1ca_s2) - sum_t'(ccsa_s2));
			mat.r11 <= to_out(sum_t'(cbca_s2));
			mat.r12 <= to_out(-(sum_t'(t2ca_s2) + sum_t'(scsa_s2)));
			mat.r20 <= to_out(-sum_t'(sccb_s2));
			mat.r21 <= to_out(sum_t'(sb_s2));
			mat.r22 <= to_out(sum_t'(cccb_s2));
		end
	end

endmodule

@@ design/euler_to_rotation_matrix_core.sv @@
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// Roll/pitch/yaw binary angles to a 3x3 Q2.14 rotation matrix (axis-swapped
// yaw-pitch-roll form).
//
//   channel   dir   payload
//   angles    in    roll_angle, pitch_angle, yaw_angle
//   matrix    out   r00 r01 r02 r10 r11 r12 r20 r21 r22
//
// One item per cycle while no stall holds (32 CORDIC stages, 3 product stages).
// The last product stage is the output register. When it holds a result not
// yet taken, the whole pipeline freezes and angles.ready drops.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_core #(
	parameter int ANGLE_WIDTH    = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic  clk,
	input  logic  arst_n,
	e2r_angle_if.sink  angles,
	e2r_mat_if.source  matrix
);
	import e2r_pkg::*;

	localparam int LAT = CORDIC_ITER + 2 + 3;

	logic           en;
	logic [LAT-1:0] vld_q;
	trig_t          sa, ca, sb, cb, sc, cc;
	mat_t           mat;

	assign en           = !vld_q[LAT-1] || matrix.ready;
	assign angles.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], angles.valid};
		end
	end

	e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cdc_a (
		.clk(clk), .en(en), .angle(angles.roll_angle), .sin_o(sa), .cos_o(ca));
	e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cdc_b (
		.clk(clk), .en(en), .angle(angles.pitch_angle), .sin_o(sb), .cos_o(cb));
	e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cdc_c (
		.clk(clk), .en(en), .angle(angles.yaw_angle), .sin_o(sc), .cos_o(cc));

	e2r_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mat (
		.clk(clk), .en(en),
		.sa(sa), .ca(ca), .sb(sb), .cb(cb), .sc(sc), .cc(cc),
		.mat(mat));

	assign matrix.valid = vld_q[LAT-1];
	assign matrix.r00   = mat.r00;
	assign matrix.r01   = mat.r01;
	assign matrix.r02   = mat.r02;
	assign matrix.r10   = mat.r10;
	assign matrix.r11   = mat.r11;
	assign matrix.r12   = mat.r12;
	assign matrix.r20   = mat.r20;
	assign matrix.r21   = mat.r21;
	assign matrix.r22   = mat.r22;

endmodule
